FILE: hw/rtl/dq_pkg.sv
`timescale 1ns / 1ps
// dq_pkg: shared types and codes for the double-ended queue
// no dependencies

package dq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_POP_BACK   = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_DUMP       = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

FILE: hw/rtl/dq_mem.sv
`timescale 1ns / 1ps
// dq_mem: slot storage, one write port and one registered read port
// depends on dq_pkg for the word width

module dq_mem
    import dq_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/dq_ctrl.sv
`timescale 1ns / 1ps
// dq_ctrl: command decode, front/back pointers, occupancy and dump walk
// depends on dq_pkg; drives the ports of dq_mem

module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int OCC_W  = 7
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2:0]               action,
    input  logic signed [WORD_W-1:0] value,
    output logic                     busy,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] item,
    output logic                     last,
    output logic                     mem_wr_en,
    output logic [ADDR_W-1:0]        mem_wr_addr,
    output logic [WORD_W-1:0]        mem_wr_data,
    output logic                     mem_rd_en,
    output logic [ADDR_W-1:0]        mem_rd_addr,
    input  logic [WORD_W-1:0]        mem_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  front_reg, front_next;
    logic [ADDR_W-1:0]  tail_reg, tail_next;
    logic [ADDR_W-1:0]  walk_reg, walk_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [OCC_W-1:0]   left_reg, left_next;
    logic               strobe_reg, strobe_next;
    status_t            status_reg, status_next;
    logic [WORD_W-1:0]  item_reg, item_next;
    logic               last_reg, last_next;
    logic               accept;
    logic               is_full;
    logic               is_empty;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == '0)
            r = ADDR_W'(DEPTH - 1);
        else
            r = p - 1'b1;
        return r;
    endfunction

    assign accept   = start && (state_reg == S_IDLE);
    assign is_full  = (occ_reg == OCC_W'(DEPTH));
    assign is_empty = (occ_reg == '0);

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        tail_next   = tail_reg;
        walk_next   = walk_reg;
        occ_next    = occ_reg;
        left_next   = left_reg;
        strobe_next = 1'b0;
        status_next = ST_OK;
        item_next   = '0;
        last_next   = 1'b1;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tail_reg;
        mem_wr_data = value;
        mem_rd_en   = 1'b0;
        mem_rd_addr = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_PUSH_BACK,
                        ACT_PUSH_FRONT:
                        begin
                            strobe_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en = 1'b1;
                                occ_next  = occ_reg + 1'b1;
                                if (action == ACT_PUSH_BACK)
                                begin
                                    mem_wr_addr = tail_reg;
                                    tail_next   = ptr_inc(tail_reg);
                                end
                                else
                                begin
                                    mem_wr_addr = ptr_dec(front_reg);
                                    front_next  = ptr_dec(front_reg);
                                end
                            end
                        end
                        ACT_POP_BACK,
                        ACT_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                occ_next   = occ_reg - 1'b1;
                                state_next = S_POP;
                                if (action == ACT_POP_BACK)
                                begin
                                    mem_rd_addr = ptr_dec(tail_reg);
                                    tail_next   = ptr_dec(tail_reg);
                                end
                                else
                                begin
                                    mem_rd_addr = front_reg;
                                    front_next  = ptr_inc(front_reg);
                                end
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (is_empty)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = front_reg;
                                walk_next   = ptr_inc(front_reg);
                                left_next   = occ_reg;
                                state_next  = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                strobe_next = 1'b1;
                item_next   = mem_rd_data;
                state_next  = S_IDLE;
            end
            S_DUMP:
            begin
                strobe_next = 1'b1;
                item_next   = mem_rd_data;
                if (left_reg == OCC_W'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    last_next   = 1'b0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = walk_reg;
                    walk_next   = ptr_inc(walk_reg);
                    left_next   = left_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            tail_reg   <= '0;
            walk_reg   <= '0;
            occ_reg    <= '0;
            left_reg   <= '0;
            strobe_reg <= 1'b0;
            status_reg <= ST_OK;
            item_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            tail_reg   <= tail_next;
            walk_reg   <= walk_next;
            occ_reg    <= occ_next;
            left_reg   <= left_next;
            strobe_reg <= strobe_next;
            status_reg <= status_next;
            item_reg   <= item_next;
            last_reg   <= last_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign status = status_reg;
    assign item   = item_reg;
    assign last   = last_reg;

    // back pointer tracks front plus occupancy
    logic [OCC_W:0] tail_sum;
    assign tail_sum = (OCC_W + 1)'(front_reg) + (OCC_W + 1)'(occ_reg);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above capacity");

    a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_sum >= (OCC_W + 1)'(DEPTH))
            ? (tail_reg == ADDR_W'(tail_sum - (OCC_W + 1)'(DEPTH)))
            : (tail_reg == ADDR_W'(tail_sum)))
        else $error("back pointer out of step");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("read and write in the same cycle");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != ST_OK)) |-> (item == '0 && last))
        else $error("refused word carries data");

    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_PUSH_BACK || action == ACT_PUSH_FRONT))
            |=> (strobe && last && item == '0))
        else $error("push gave no result word");

endmodule

FILE: hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// double_ended_queue: bounded deque of signed 32-bit words
// depends on dq_pkg, dq_ctrl and dq_mem
//
// a command is taken on a rising edge with start high and busy low; action
// selects push back, pop back, push front, pop front or dump, value is the
// word to push. each result word appears for one cycle with strobe high,
// carrying status, item and last; the receiver cannot stall.
// the first result word appears the cycle after acceptance for pushes and
// refused commands; for pops and dumps it passes the registered read of
// the slot memory and then the result registers. pushes and any empty or
// full response leave busy low; a pop or dump holds busy high while it
// runs. a dump gives one word per cycle, last set on the final one.
// unknown actions are dropped.
// reset clears the pointers and occupancy, so the queue starts empty; the
// slot memory itself is not cleared and needs no clearing pass.

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2:0]               action,
    input  logic signed [WORD_W-1:0] value,
    output logic                     busy,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] item,
    output logic                     last
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [WORD_W-1:0] mem_rd_data;

    dq_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .OCC_W  (OCC_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .value       (value),
        .busy        (busy),
        .strobe      (strobe),
        .status      (status),
        .item        (item),
        .last        (last),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    dq_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
